[design/htfd_pkg.sv]
// ----------------------------------------------------------------------------
// htfd_pkg: shared types, constants and CRC helper for the frame decoder
// Scale factors, offsets, status codes and the stage payload structs.
// ----------------------------------------------------------------------------
package htfd_pkg;

    // CRC-8, x^8+x^5+x^4+1, MSB first
    localparam logic [7:0] CRC_POLY = 8'h31;

    // Register index of the one configuration register
    localparam logic REG_REPORT_FAHRENHEIT = 1'b0;

    // Datapath widths
    localparam int SAMPLE_W  = 16;
    localparam int K_W       = 19;
    localparam int PROD_W    = SAMPLE_W + K_W;
    localparam int Q_W       = PROD_W - 16;
    localparam int RECIP_W   = 20;
    localparam int DIV_W     = Q_W + RECIP_W;
    localparam int DIV_SHIFT = 23;
    localparam int SCALED_W  = 15;
    localparam int VALUE_W   = 16;

    // Scale factors applied before the >>16
    localparam logic [K_W-1:0] K_HUM  = 19'd12500;
    localparam logic [K_W-1:0] K_DEGC = 19'd17572;
    localparam logic [K_W-1:0] K_DEGF = 19'd316296;

    // ceil(2^23 / 10): exact floor division by ten for the Fahrenheit range
    localparam logic [RECIP_W-1:0] RECIP_TEN = 20'd838861;

    localparam logic signed [VALUE_W-1:0] OFF_HUM  = 16'sd600;
    localparam logic signed [VALUE_W-1:0] OFF_DEGC = 16'sd4685;
    localparam logic signed [VALUE_W-1:0] OFF_DEGF = 16'sd5233;

    typedef enum logic [1:0] {
        STATUS_OK   = 2'd0,
        STATUS_CRC  = 2'd1,
        STATUS_KIND = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        MODE_HUM  = 2'd0,
        MODE_DEGC = 2'd1,
        MODE_DEGF = 2'd2
    } mode_t;

    // Stage 1 payload: raw frame plus CRC over the high byte
    typedef struct packed {
        logic       op;
        logic       fahr;
        logic [7:0] hi;
        logic [7:0] lo;
        logic [7:0] rx;
        logic [7:0] crc_hi;
    } s1_t;

    // Stage 2 payload: verdict and raw scaled product
    typedef struct packed {
        status_t           status;
        mode_t             mode;
        logic [PROD_W-1:0] prod;
    } s2_t;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++)
        begin
            if (c[7])
            begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

[design/htfd_crc_stage.sv]
// ----------------------------------------------------------------------------
// htfd_crc_stage: first pipeline stage
// Captures a frame beat and folds the high byte into the CRC.
// ----------------------------------------------------------------------------
module htfd_crc_stage
    import htfd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       op,
    input  logic       fahr,
    input  logic [7:0] hi,
    input  logic [7:0] lo,
    input  logic [7:0] rx,
    output logic       s1_valid,
    output s1_t        s1
);

    logic s1_valid_reg;
    s1_t  s1_reg;
    s1_t  s1_next;

    always_comb
    begin
        s1_next.op     = op;
        s1_next.fahr   = fahr;
        s1_next.hi     = hi;
        s1_next.lo     = lo;
        s1_next.rx     = rx;
        s1_next.crc_hi = crc8_byte(8'h00, hi);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg <= s1_next;
    end

    assign s1_valid = s1_valid_reg;
    assign s1       = s1_reg;

endmodule

[design/htfd_mul_stage.sv]
// ----------------------------------------------------------------------------
// htfd_mul_stage: second pipeline stage
// Finishes the CRC, checks the kind bit and multiplies by the scale factor.
// ----------------------------------------------------------------------------
module htfd_mul_stage
    import htfd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic s1_valid,
    input  s1_t  s1,
    output logic s2_valid,
    output s2_t  s2
);

    logic                 s2_valid_reg;
    s2_t                  s2_reg;
    s2_t                  s2_next;
    logic [7:0]           crc;
    logic [SAMPLE_W-1:0]  sample;
    logic [K_W-1:0]       k;

    always_comb
    begin
        crc    = crc8_byte(s1.crc_hi, s1.lo);
        sample = {s1.hi, s1.lo[7:2], 2'b00};

        if (crc != s1.rx)
        begin
            s2_next.status = STATUS_CRC;
        end
        else if (s1.lo[1] != s1.op)
        begin
            s2_next.status = STATUS_KIND;
        end
        else
        begin
            s2_next.status = STATUS_OK;
        end

        // humidity ignores the unit setting
        if (s1.op)
        begin
            s2_next.mode = MODE_HUM;
            k            = K_HUM;
        end
        else if (s1.fahr)
        begin
            s2_next.mode = MODE_DEGF;
            k            = K_DEGF;
        end
        else
        begin
            s2_next.mode = MODE_DEGC;
            k            = K_DEGC;
        end

        s2_next.prod = {{K_W{1'b0}}, sample} * {{SAMPLE_W{1'b0}}, k};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_reg <= s2_next;
    end

    assign s2_valid = s2_valid_reg;
    assign s2       = s2_reg;

endmodule

[design/htfd_out_stage.sv]
// ----------------------------------------------------------------------------
// htfd_out_stage: third and fourth pipeline stages
// Divides the Fahrenheit product by ten, removes the offset, drives results.
// ----------------------------------------------------------------------------
module htfd_out_stage
    import htfd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s2_valid,
    input  s2_t                 s2,
    output logic                done,
    output logic [1:0]          status,
    output logic [VALUE_W-1:0]  value_centi
);

    // stage 3
    logic              s3_valid_reg;
    status_t           s3_status_reg;
    mode_t             s3_mode_reg;
    logic [Q_W-1:0]    s3_q_reg;
    logic [DIV_W-1:0]  s3_div_reg;
    logic [Q_W-1:0]    q_next;
    logic [DIV_W-1:0]  div_next;

    // stage 4
    logic                       done_reg;
    status_t                    status_reg;
    logic signed [VALUE_W-1:0]  value_reg;
    logic signed [VALUE_W-1:0]  value_next;
    logic [SCALED_W-1:0]        scaled;
    logic signed [VALUE_W-1:0]  offset;

    always_comb
    begin
        q_next   = s2.prod[PROD_W-1:16];
        div_next = {{RECIP_W{1'b0}}, q_next} * {{Q_W{1'b0}}, RECIP_TEN};
    end

    always_comb
    begin
        case (s3_mode_reg)
            MODE_DEGF:
            begin
                scaled = s3_div_reg[DIV_SHIFT +: SCALED_W];
                offset = OFF_DEGF;
            end
            MODE_HUM:
            begin
                scaled = s3_q_reg[SCALED_W-1:0];
                offset = OFF_HUM;
            end
            default:
            begin
                scaled = s3_q_reg[SCALED_W-1:0];
                offset = OFF_DEGC;
            end
        endcase

        if (s3_status_reg == STATUS_OK)
        begin
            value_next = $signed({1'b0, scaled}) - offset;
        end
        else
        begin
            value_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s3_valid_reg <= s2_valid;
            done_reg     <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s3_status_reg <= s2.status;
        s3_mode_reg   <= s2.mode;
        s3_q_reg      <= q_next;
        s3_div_reg    <= div_next;
        status_reg    <= s3_status_reg;
        value_reg     <= value_next;
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign value_centi = value_reg;

endmodule

[design/humidity_temp_frame_decoder.sv]
// ----------------------------------------------------------------------------
// humidity_temp_frame_decoder: sensor reply checker and scaler
// CRC-8 check, kind check and fixed-point scaling of a three-byte reply.
// ----------------------------------------------------------------------------
// Usage:
//   Frame channel: a beat (operation, high_byte, low_byte, crc_byte) is taken
//   on any rising edge with start high and busy low. busy is tied low, so a
//   new frame may be issued every cycle.
//   Result channel: done pulses for one cycle with status and value_centi;
//   the receiver has no way to hold results back and must take each beat.
//   Pipeline: a frame passes four register stages (CRC, multiply,
//   divide-by-ten, offset) on its way to the result beat.
//   Throughput: one frame per cycle, set by the fully pipelined datapath.
//   Config port: APB-style, one register at byte address 0,
//   report_fahrenheit in bit 0. Change it only while no frames are in
//   flight; each frame samples it on entry.
//   Reset: rst_n clears the pipeline valid bits and report_fahrenheit;
//   no result beat is produced until a frame has been taken.
// ----------------------------------------------------------------------------
module humidity_temp_frame_decoder
    import htfd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // frame channel
    input  logic                start,
    output logic                busy,
    input  logic                operation,
    input  logic [7:0]          high_byte,
    input  logic [7:0]          low_byte,
    input  logic [7:0]          crc_byte,
    // result channel
    output logic                done,
    output logic [1:0]          status,
    output logic [VALUE_W-1:0]  value_centi,
    // config port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    logic fahr_reg;
    logic fahr_next;
    logic cfg_wr;
    logic accept;
    logic s1_valid;
    s1_t  s1;
    logic s2_valid;
    s2_t  s2;

    // never stalls: every start beat is taken
    assign busy   = 1'b0;
    assign pready = 1'b1;
    assign accept = start && !busy;

    // register file: index is the word address bit
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        fahr_next = fahr_reg;
        if (cfg_wr && paddr[2] == REG_REPORT_FAHRENHEIT)
        begin
            fahr_next = pwdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fahr_reg <= 1'b0;
        end
        else
        begin
            fahr_reg <= fahr_next;
        end
    end

    // out-of-range addresses read as zero
    assign prdata = (paddr[2] == REG_REPORT_FAHRENHEIT) ? {31'b0, fahr_reg} : 32'b0;

    // stage 1: capture, CRC over the high byte
    htfd_crc_stage u_crc_stage
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (accept),
        .op       (operation),
        .fahr     (fahr_reg),
        .hi       (high_byte),
        .lo       (low_byte),
        .rx       (crc_byte),
        .s1_valid (s1_valid),
        .s1       (s1)
    );

    // stage 2: CRC over the low byte, kind check, scale multiply
    htfd_mul_stage u_mul_stage
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s1_valid (s1_valid),
        .s1       (s1),
        .s2_valid (s2_valid),
        .s2       (s2)
    );

    // stages 3 and 4: divide by ten for Fahrenheit, offset, result beat
    htfd_out_stage u_out_stage
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .s2_valid    (s2_valid),
        .s2          (s2),
        .done        (done),
        .status      (status),
        .value_centi (value_centi)
    );

`ifndef SYNTHESIS
    // every taken frame yields exactly one result beat
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> ##3 done)
        else $error("frame did not produce a result beat");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> ##3 !done)
        else $error("result beat without a frame");

    a_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        done && status != STATUS_OK |-> value_centi == '0)
        else $error("non-zero value on a failed frame");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> status == STATUS_OK || status == STATUS_CRC || status == STATUS_KIND)
        else $error("undefined status code");
`endif

endmodule

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: frame decoder testbench
// Drives three-byte sensor replies with valid and broken CRCs and status
// bits, in Celsius and Fahrenheit mode, and checks every result beat
// against an in-bench decoder of the frame.
// ----------------------------------------------------------------------------
module tb_top;
    import htfd_pkg::*;

    // Register stages between a taken frame and its result beat
    localparam int PIPE_DEPTH  = 4;
    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_GAP     = 12;

    // Register i lives at byte address 4*i; index 1 decodes to nothing
    localparam logic [2:0] ADDR_FAHRENHEIT = {REG_REPORT_FAHRENHEIT, 2'b00};
    localparam logic [2:0] ADDR_UNMAPPED   = 3'd4;

    typedef struct {
        status_t     status;
        logic [15:0] value;
    } reading_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        operation;
    logic [7:0]  high_byte;
    logic [7:0]  low_byte;
    logic [7:0]  crc_byte;
    logic        done;
    logic [1:0]  status;
    logic [VALUE_W-1:0] value_centi;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Bench copy of report_fahrenheit, updated at the write edge
    logic        fahrenheit_mode;
    reading_t    pending_readings[$];
    reading_t    oldest_reading;
    int          mismatch_count;
    int          cycle_count;

    humidity_temp_frame_decoder DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .operation   (operation),
        .high_byte   (high_byte),
        .low_byte    (low_byte),
        .crc_byte    (crc_byte),
        .done        (done),
        .status      (status),
        .value_centi (value_centi),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Decoder of one frame
    // ------------------------------------------------------------------

    // CRC-8 over {hi, lo}, MSB first, zero seed, no final xor
    function automatic logic [7:0] crc_of_sample(input logic [7:0] hi, input logic [7:0] lo);
        logic [15:0] bits;
        logic [7:0]  crc;
        logic        feedback;
        bits = {hi, lo};
        crc  = 8'h00;
        for (int i = 15; i >= 0; i--)
        begin
            feedback = crc[7] ^ bits[i];
            crc      = {crc[6:0], 1'b0} ^ (feedback ? CRC_POLY : 8'h00);
        end
        return crc;
    endfunction

    function automatic reading_t decode_reading(input logic op, input logic [7:0] hi,
                                                input logic [7:0] lo, input logic [7:0] rx,
                                                input logic fahr);
        reading_t    r;
        longint      sample;
        longint      scaled;
        r.status = STATUS_OK;
        r.value  = 16'h0000;
        // CRC is checked before the kind bit, so a double fault reads as CRC
        if (crc_of_sample(hi, lo) != rx)
        begin
            r.status = STATUS_CRC;
        end
        else if (lo[1] != op)
        begin
            r.status = STATUS_KIND;
        end
        else
        begin
            sample = longint'({hi, lo[7:2], 2'b00});
            if (op)
                scaled = (sample * 12500) / 65536 - 600;    // register ignored here
            else if (fahr)
                scaled = (sample * 316296) / 655360 - 5233;
            else
                scaled = (sample * 17572) / 65536 - 4685;
            r.value = 16'(scaled);
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Mismatch reporting and result checking
    // ------------------------------------------------------------------

    task automatic flag_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // done marks a one-cycle result beat; it cannot be held off, so every
    // high sample at a rising edge is one accepted beat
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            if (pending_readings.size() == 0)
            begin
                flag_mismatch("result beat with no frame outstanding");
            end
            else
            begin
                oldest_reading = pending_readings.pop_front();
                if (status !== oldest_reading.status)
                    flag_mismatch($sformatf("status %0d, expected %0d",
                                            status, oldest_reading.status));
                if (value_centi !== oldest_reading.value)
                    flag_mismatch($sformatf("value_centi %0d, expected %0d",
                                            $signed(value_centi),
                                            $signed(oldest_reading.value)));
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Frame channel and config port drivers (all changes on the falling edge)
    // ------------------------------------------------------------------

    // Send one frame after 'gap' idle cycles. With gap 0 start stays high
    // from the previous beat, so it is never dropped and raised in one step.
    task automatic issue_frame(input logic op, input logic [7:0] hi, input logic [7:0] lo,
                               input logic [7:0] rx, input int gap);
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start     <= 1'b1;
        operation <= op;
        high_byte <= hi;
        low_byte  <= lo;
        crc_byte  <= rx;
        do @(posedge clk); while (busy !== 1'b0);
        pending_readings.push_back(decode_reading(op, hi, lo, rx, fahrenheit_mode));
    endtask

    // Well-formed frame: correct CRC, kind bit matching the request
    task automatic issue_good_frame(input logic op, input logic [7:0] hi,
                                    input logic [7:0] lo, input int gap);
        logic [7:0] lo_marked;
        lo_marked = {lo[7:2], op, lo[0]};
        issue_frame(op, hi, lo_marked, crc_of_sample(hi, lo_marked), gap);
    endtask

    // Drop start, let every outstanding result arrive, then let the pipe run dry
    task automatic settle_pipeline();
        @(negedge clk);
        start <= 1'b0;
        while (pending_readings.size() != 0) @(posedge clk);
        repeat (PIPE_DEPTH + 2) @(posedge clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        if (addr == ADDR_FAHRENHEIT)
            fahrenheit_mode = data[0];
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_read_check(input logic [2:0] addr);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        if (prdata !== {31'b0, fahrenheit_mode})
            flag_mismatch($sformatf("prdata %h, expected %h", prdata,
                                    {31'b0, fahrenheit_mode}));
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset value, write to an unmapped index, all-ones and upper-bits-only data
    task automatic test_register_access();
        apb_read_check(ADDR_FAHRENHEIT);
        apb_write(ADDR_UNMAPPED, 32'hFFFF_FFFF);
        apb_read_check(ADDR_FAHRENHEIT);
        apb_write(ADDR_FAHRENHEIT, 32'hFFFF_FFFF);
        apb_read_check(ADDR_FAHRENHEIT);
        apb_write(ADDR_FAHRENHEIT, 32'hFFFF_FFFE);
        apb_read_check(ADDR_FAHRENHEIT);
    endtask

    // Sample extremes in Celsius and humidity; bit 0 of low byte must not matter
    task automatic test_celsius_extremes();
        issue_good_frame(1'b0, 8'h00, 8'h00, 0);
        issue_good_frame(1'b0, 8'hFF, 8'hFF, 0);
        issue_good_frame(1'b0, 8'hFF, 8'hFC, 0);
        issue_good_frame(1'b1, 8'h00, 8'h01, 1);
        issue_good_frame(1'b1, 8'hFF, 8'hFF, 0);
        issue_good_frame(1'b1, 8'h7F, 8'h80, 0);
        settle_pipeline();
    endtask

    // Fahrenheit extremes; humidity must ignore the unit setting
    task automatic test_fahrenheit_extremes();
        apb_write(ADDR_FAHRENHEIT, 32'h0000_0001);
        issue_good_frame(1'b0, 8'h00, 8'h00, 0);
        issue_good_frame(1'b0, 8'hFF, 8'hFF, 0);
        issue_good_frame(1'b0, 8'h68, 8'h3A, 2);
        issue_good_frame(1'b1, 8'hFF, 8'hFE, 0);
        issue_good_frame(1'b1, 8'h00, 8'h00, 0);
        settle_pipeline();
        apb_write(ADDR_FAHRENHEIT, 32'h0000_0000);
    endtask

    // Bad CRC, wrong kind bit each way, and both faults together
    task automatic test_error_codes();
        logic [7:0] good;
        good = crc_of_sample(8'h5A, 8'h68);
        issue_frame(1'b0, 8'h5A, 8'h68, good ^ 8'h01, 0);
        issue_frame(1'b0, 8'h5A, 8'h68, ~good, 0);
        issue_frame(1'b1, 8'h5A, 8'h68, good, 0);        // humidity asked, temp sent
        good = crc_of_sample(8'hA5, 8'h96);
        issue_frame(1'b0, 8'hA5, 8'h96, good, 3);        // temp asked, humidity sent
        issue_frame(1'b0, 8'hA5, 8'h96, good ^ 8'h80, 0); // both faults: CRC wins
        issue_frame(1'b1, 8'h00, 8'h00, 8'hFF, 0);
        issue_frame(1'b0, 8'hFF, 8'hFF, 8'h00, 0);
        settle_pipeline();
    endtask

    // Mostly well-formed frames with random content, the rest broken or noise.
    // Gaps come in runs: some runs of 32 beats are back to back.
    task automatic test_random_frames(input int count, input logic fahr);
        logic       op;
        logic [7:0] hi;
        logic [7:0] lo;
        logic [7:0] good;
        int         gap;
        int         pick;
        logic       burst;
        burst = 1'b0;
        apb_write(ADDR_FAHRENHEIT, {31'b0, fahr});
        for (int i = 0; i < count; i++)
        begin
            if (i % 32 == 0)
                burst = ($urandom_range(0, 2) == 0);
            gap  = burst ? 0 : $urandom_range(0, MAX_GAP);
            op   = 1'($urandom_range(0, 1));
            hi   = 8'($urandom_range(0, 255));
            lo   = 8'($urandom_range(0, 255));
            pick = $urandom_range(0, 99);
            if (pick < 75)
            begin
                issue_good_frame(op, hi, lo, gap);
            end
            else if (pick < 85)
            begin
                lo   = {lo[7:2], ~op, lo[0]};
                good = crc_of_sample(hi, lo);
                issue_frame(op, hi, lo, good ^ 8'($urandom_range(1, 255)), gap);
            end
            else if (pick < 95)
            begin
                lo = {lo[7:2], ~op, lo[0]};
                issue_frame(op, hi, lo, crc_of_sample(hi, lo), gap);
            end
            else
            begin
                issue_frame(op, hi, lo, 8'($urandom_range(0, 255)), gap);
            end
        end
        settle_pipeline();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n           = 1'b0;
        start           = 1'b0;
        operation       = 1'b0;
        high_byte       = 8'h00;
        low_byte        = 8'h00;
        crc_byte        = 8'h00;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = 3'd0;
        pwdata          = 32'h0;
        fahrenheit_mode = 1'b0;
        mismatch_count  = 0;
        cycle_count     = 0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_register_access();
        test_celsius_extremes();
        test_fahrenheit_extremes();
        test_error_codes();
        // unit setting flips between runs, ending back at reset value
        test_random_frames(150, 1'b1);
        test_random_frames(150, 1'b0);
        test_random_frames(150, 1'b1);
        test_random_frames(150, 1'b0);
        test_random_frames(150, 1'b1);
        apb_write(ADDR_FAHRENHEIT, 32'h0);
        apb_read_check(ADDR_FAHRENHEIT);

        // settle_pipeline has already drained; a short tail for stray beats
        repeat (PIPE_DEPTH * 4) @(posedge clk);
        if (mismatch_count == 0 && pending_readings.size() == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

[filelist.f]
design/htfd_pkg.sv
design/htfd_crc_stage.sv
design/htfd_mul_stage.sv
design/htfd_out_stage.sv
design/humidity_temp_frame_decoder.sv
dv/tb_top.sv
